/* sv/rhc_pkg.sv */
package rhc_pkg;

   localparam int CHAN_W      = 8;
   localparam int QUO_W       = 8;
   // dividend up to 6*255*255, divisor up to 6*255
   localparam int NUM_W       = 19;
   localparam int DEN_W       = 11;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [NUM_W-1:0]  hue_num;
      logic [DEN_W-1:0]  hue_den;
      logic [NUM_W-1:0]  sat_num;
      logic [DEN_W-1:0]  sat_den;
      logic [CHAN_W-1:0] bright;
   } item_type;

endpackage

/* sv/rhc_front.sv */
module rhc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rhc_pkg::CHAN_W-1:0]    req_red,
   input  logic [rhc_pkg::CHAN_W-1:0]    req_green,
   input  logic [rhc_pkg::CHAN_W-1:0]    req_blue,
   output logic                          busy,
   input  logic                          queue_full,
   output logic                          push,
   output rhc_pkg::item_type             push_item
);

   localparam int CW = rhc_pkg::CHAN_W;
   localparam int NW = rhc_pkg::NUM_W;
   localparam int DW = rhc_pkg::DEN_W;

   logic              valid_ff, valid_in;
   rhc_pkg::item_type item_ff, item_in;
   logic              accept;

   logic [CW-1:0]        hi, lo, d;
   logic signed [CW+1:0] diff;
   logic [DW-1:0]        base, six_d, num;
   logic signed [DW+1:0] num_s;
   logic                 wrap;

   assign busy      = valid_ff && queue_full;
   assign push      = valid_ff && !queue_full;
   assign accept    = start && !busy;
   assign push_item = item_ff;

   always_comb begin
      hi = req_red;
      if (req_green > hi) hi = req_green;
      if (req_blue > hi) hi = req_blue;
      lo = req_red;
      if (req_green < lo) lo = req_green;
      if (req_blue < lo) lo = req_blue;
      d     = hi - lo;
      six_d = DW'({d, 1'b0}) + DW'({d, 2'b00});

      // sector pick, red first, then green, then blue
      if (hi == req_red) begin
         diff = $signed({2'b00, req_green}) - $signed({2'b00, req_blue});
         base = '0;
         wrap = diff < 0;
      end else if (hi == req_green) begin
         diff = $signed({2'b00, req_blue}) - $signed({2'b00, req_red});
         base = DW'({d, 1'b0});
         wrap = 1'b0;
      end else begin
         diff = $signed({2'b00, req_red}) - $signed({2'b00, req_green});
         base = DW'({d, 2'b00});
         wrap = 1'b0;
      end
      num_s = $signed({2'b00, base}) + (DW+2)'(diff);
      if (wrap) num_s = num_s + $signed({2'b00, six_d});
      num = num_s[DW-1:0];

      item_in.hue_num = NW'({num, 8'h00}) - NW'(num);
      item_in.hue_den = (d == '0) ? DW'(1) : six_d;
      item_in.sat_num = NW'({d, 8'h00}) - NW'(d);
      item_in.sat_den = (hi == '0) ? DW'(1) : DW'(hi);
      item_in.bright  = hi;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

/* sv/rhc_queue.sv */
module rhc_queue #(
   parameter int DEPTH = rhc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rhc_pkg::item_type push_item,
   output logic              full,
   output logic              pop_valid,
   output rhc_pkg::item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rhc_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;

   // back end never stalls, so the head leaves as soon as it is there
   assign pop       = count_ff != '0;
   assign pop_valid = pop;
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign full      = count_ff == CNT_W'(DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/rhc_div.sv */
module rhc_div (
   input  logic                       clock,
   input  logic [rhc_pkg::NUM_W-1:0]  num,
   input  logic [rhc_pkg::DEN_W-1:0]  den,
   output logic [rhc_pkg::QUO_W-1:0]  quo
);

   localparam int NW = rhc_pkg::NUM_W;
   localparam int DW = rhc_pkg::DEN_W;
   localparam int QW = rhc_pkg::QUO_W;

   // restoring divide, one quotient bit per stage, msb first;
   // quotient is known to fit in QW bits
   logic [NW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [1:QW];
   logic [NW-1:0] trial  [QW];
   logic [QW-1:0] take;

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         trial[s] = NW'(den_ff[s]) << (QW - 1 - s);
         take[s]  = rem_ff[s] >= trial[s];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      den_ff[0] <= den;
      quo_ff[1] <= QW'(take[0]);
      for (int s = 0; s < QW - 1; s++) begin
         rem_ff[s+1] <= take[s] ? rem_ff[s] - trial[s] : rem_ff[s];
         den_ff[s+1] <= den_ff[s];
      end
      for (int s = 1; s < QW; s++) begin
         quo_ff[s+1] <= {quo_ff[s][QW-2:0], take[s]};
      end
   end

   assign quo = quo_ff[QW];

endmodule

/* sv/rhc_back.sv */
module rhc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  rhc_pkg::item_type           in_item,
   output logic                        rsp_strobe,
   output logic [rhc_pkg::CHAN_W-1:0]  rsp_hue,
   output logic [rhc_pkg::CHAN_W-1:0]  rsp_saturation,
   output logic [rhc_pkg::CHAN_W-1:0]  rsp_brightness
);

   localparam int QW = rhc_pkg::QUO_W;
   localparam int CW = rhc_pkg::CHAN_W;

   // valid and brightness ride alongside the divider stages
   logic [QW:0]   valid_ff;
   logic [CW-1:0] bright_ff [QW+1];
   logic [QW-1:0] hue_quo, sat_quo;

   rhc_div u_hue_div (
      .clock (clock),
      .num   (in_item.hue_num),
      .den   (in_item.hue_den),
      .quo   (hue_quo)
   );

   rhc_div u_sat_div (
      .clock (clock),
      .num   (in_item.sat_num),
      .den   (in_item.sat_den),
      .quo   (sat_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      bright_ff[0] <= in_item.bright;
      for (int s = 0; s < QW; s++) begin
         bright_ff[s+1] <= bright_ff[s];
      end
   end

   assign rsp_strobe     = valid_ff[QW];
   assign rsp_hue        = CW'(hue_quo);
   assign rsp_saturation = CW'(sat_quo);
   assign rsp_brightness = bright_ff[QW];

endmodule

/* sv/rgb_to_hsv_converter.sv */
// RGB to HSV for 8-bit pixels: takes one pixel per clock and gives hue (a full circle
// scaled to 255, so 0..254), saturation and value (the largest channel). Each result
// appears on rsp_* for one cycle with rsp_strobe, once the pixel has passed the front
// register, the queue and the divider pipeline; the receiver cannot hold results off,
// and it need not. The front end finds max, min and the hue sector and forms the two
// dividends, a short queue follows, and the back end runs two 8-stage pipelined
// restoring dividers that settle one quotient bit per stage, so the divide pipeline
// sets the one-pixel-per-clock rate. Since the back end never stalls, busy stays low.
module rgb_to_hsv_converter #(
   parameter int QUEUE_DEPTH = rhc_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [rhc_pkg::CHAN_W-1:0]  req_red,
   input  logic [rhc_pkg::CHAN_W-1:0]  req_green,
   input  logic [rhc_pkg::CHAN_W-1:0]  req_blue,
   output logic                        rsp_strobe,
   output logic [rhc_pkg::CHAN_W-1:0]  rsp_hue,
   output logic [rhc_pkg::CHAN_W-1:0]  rsp_saturation,
   output logic [rhc_pkg::CHAN_W-1:0]  rsp_brightness
);

   // edges from accepting an item to accepting its result: front register, queue,
   // divider input register and one register per quotient bit
   localparam int LATENCY = rhc_pkg::QUO_W + 3;

   logic              queue_full, push, pop_valid;
   rhc_pkg::item_type push_item, pop_item;

   rhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .busy       (busy),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   rhc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   rhc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (pop_valid),
      .in_item        (pop_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

`ifndef SYNTHESIS
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("front end stalled although the back end drains every cycle");

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LATENCY rsp_strobe)
      else $error("accepted item did not come out after the fixed latency");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching accepted item");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_hue != 8'hff)
      else $error("hue quotient out of range");
`endif

endmodule
